[sv/bmhq_pkg.sv]
// Package for the binary min-heap queue: sizes, transaction structs,
// status codes and the controller/datapath command interface.
// No dependencies.
package bmhq_pkg;

    // Heap sizing
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // Child index width: 2*pos+2 can reach 2*CAPACITY
    localparam int CHILD_W  = ADDR_W + 2;

    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    // Action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Input transaction
    typedef struct packed {
        logic               action;
        logic signed [31:0] priority_req;
        logic [31:0]        payload;
    } in_t;

    // Result transaction
    typedef struct packed {
        logic signed [31:0] head_priority;
        logic [31:0]        head_payload;
        logic [10:0]        entry_count;
        logic               is_empty;
        logic [1:0]         status;
    } out_t;

    // One heap slot
    typedef struct packed {
        logic signed [31:0] prio;
        logic [31:0]        load;
    } entry_t;

    // Datapath operations
    typedef enum logic [2:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_UP_READ,
        DP_UP_MOVE,
        DP_PLACE,
        DP_LAST_READ,
        DP_LAST_LOAD,
        DP_DN_READ
    } dp_op_t;

    // Controller to datapath
    typedef struct packed {
        dp_op_t op;
        logic   dn_move;   // write best child at pos, descend
        logic   out_load;  // capture the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;      // count equals capacity
        logic empty;     // count is zero
        logic pos_zero;  // sift position is the root
        logic up_less;   // item beats the parent just read
        logic dn_leaf;   // no left child at the sift position
        logic dn_stop;   // item beats both children just read
    } stat_t;

endpackage

[sv/bmhq_datapath.sv]
// Datapath of the binary min-heap queue: heap memory (one write, two
// registered reads), count, sift position, held item, root copy, result.
// Depends on bmhq_pkg.
module bmhq_datapath import bmhq_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  in_t   s_data,
    input  cmd_t  cmd,
    output stat_t st,
    output out_t  m_data
);

    entry_t mem [CAPACITY];

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    entry_t            item_reg, item_next;
    logic [1:0]        status_reg, status_next;
    entry_t            head_reg;
    out_t              out_reg;
    entry_t            rdata_a, rdata_b;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
    entry_t            wdata;

    logic [ADDR_W-1:0]  parent;
    logic [CHILD_W-1:0] lc, rc, cnt_ext;
    logic               l_less, rc_valid, r_best;
    logic signed [31:0] l_or_item;

    // Index arithmetic
    assign parent  = ADDR_W'((pos_reg - 1'b1) >> 1);
    assign lc      = {1'b0, pos_reg, 1'b1};
    assign rc      = lc + 1'b1;
    assign cnt_ext = CHILD_W'(cnt_reg);

    // Child selection: left wins a tie
    assign l_less    = $signed(rdata_a.prio) < $signed(item_reg.prio);
    assign rc_valid  = rc < cnt_ext;
    assign l_or_item = l_less ? rdata_a.prio : item_reg.prio;
    assign r_best    = rc_valid && ($signed(rdata_b.prio) < $signed(l_or_item));

    // Status to controller
    assign st.full     = (cnt_reg == CAP_COUNT);
    assign st.empty    = (cnt_reg == '0);
    assign st.pos_zero = (pos_reg == '0);
    assign st.up_less  = $signed(item_reg.prio) < $signed(rdata_a.prio);
    assign st.dn_leaf  = !(lc < cnt_ext);
    assign st.dn_stop  = !l_less && !r_best;

    // Next state and memory port control
    always_comb begin
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        item_next   = item_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = pos_reg;
        wdata       = item_reg;
        raddr_a     = parent;
        raddr_b     = rc[ADDR_W-1:0];
        case (cmd.op)
            DP_ACCEPT: begin
                item_next.prio = s_data.priority_req;
                item_next.load = s_data.payload;
                pos_next       = cnt_reg[ADDR_W-1:0];
                status_next    = ST_OK;
                if (s_data.action == ACT_INSERT) begin
                    if (st.full) begin
                        status_next = ST_FULL;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end else begin
                    if (st.empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            DP_UP_READ: begin
                raddr_a = parent;
            end
            DP_UP_MOVE: begin
                we       = 1'b1;
                wdata    = rdata_a;
                pos_next = parent;
            end
            DP_PLACE: begin
                we = 1'b1;
            end
            DP_LAST_READ: begin
                raddr_a = cnt_reg[ADDR_W-1:0];
            end
            DP_LAST_LOAD: begin
                item_next = rdata_a;
                pos_next  = '0;
            end
            DP_DN_READ: begin
                raddr_a = lc[ADDR_W-1:0];
                raddr_b = rc[ADDR_W-1:0];
            end
            default: begin
            end
        endcase
        // Descend into the winning child
        if (cmd.dn_move) begin
            we       = 1'b1;
            wdata    = r_best ? rdata_b : rdata_a;
            pos_next = r_best ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];
        end
    end

    // Heap memory
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

    // Count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload registers, root copy and result register
    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        item_reg   <= item_next;
        status_reg <= status_next;
        if (we && (waddr == '0)) begin
            head_reg <= wdata;
        end
        if (cmd.out_load) begin
            out_reg.head_priority <= st.empty ? '0 : head_reg.prio;
            out_reg.head_payload  <= st.empty ? '0 : head_reg.load;
            out_reg.entry_count   <= 11'(cnt_reg);
            out_reg.is_empty      <= st.empty;
            out_reg.status        <= status_reg;
        end
    end

    assign m_data = out_reg;

endmodule

[sv/bmhq_ctrl.sv]
// Controller of the binary min-heap queue: one-hot sequencer for the
// sift loops and the handshake on both channels.
// Depends on bmhq_pkg.
module bmhq_ctrl import bmhq_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  logic  s_action,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  stat_t st,
    output cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_UP_RD   = 8'b0000_0010,
        S_UP_CMP  = 8'b0000_0100,
        S_LAST_RD = 8'b0000_1000,
        S_LAST_LD = 8'b0001_0000,
        S_DN_RD   = 8'b0010_0000,
        S_DN_CMP  = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd.op       = DP_NOP;
        cmd.dn_move  = 1'b0;
        cmd.out_load = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op = DP_ACCEPT;
                    if (s_action == ACT_INSERT) begin
                        state_next = st.full ? S_DONE : S_UP_RD;
                    end else begin
                        state_next = st.empty ? S_DONE : S_LAST_RD;
                    end
                end
            end
            S_UP_RD: begin
                if (st.pos_zero) begin
                    cmd.op     = DP_PLACE;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = DP_UP_READ;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (st.up_less) begin
                    cmd.op     = DP_UP_MOVE;
                    state_next = S_UP_RD;
                end else begin
                    cmd.op     = DP_PLACE;
                    state_next = S_DONE;
                end
            end
            S_LAST_RD: begin
                // Heap went empty: nothing to move
                if (st.empty) begin
                    state_next = S_DONE;
                end else begin
                    cmd.op     = DP_LAST_READ;
                    state_next = S_LAST_LD;
                end
            end
            S_LAST_LD: begin
                cmd.op     = DP_LAST_LOAD;
                state_next = S_DN_RD;
            end
            S_DN_RD: begin
                if (st.dn_leaf) begin
                    cmd.op     = DP_PLACE;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = DP_DN_READ;
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (st.dn_stop) begin
                    cmd.op     = DP_PLACE;
                    state_next = S_DONE;
                end else begin
                    cmd.dn_move = 1'b1;
                    state_next  = S_DN_RD;
                end
            end
            S_DONE: begin
                // Wait for the result register to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[sv/binary_min_heap_queue_top.sv]
// Binary min-heap priority queue: top level joining controller and datapath.
// Depends on bmhq_pkg, bmhq_ctrl and bmhq_datapath.
//
// Usage:
//   s_ channel carries one request per transaction: action 0 inserts
//   (priority_req, payload), action 1 removes the minimum entry.
//   m_ channel returns exactly one result per request: root entry, count,
//   is_empty and status (ok, insert rejected when full, remove on empty).
//   Requests are handled one at a time; s_ready is high only while idle.
//   Each sift level is a registered read and a compare/write step: an
//   insert rises toward the root, a remove sinks the moved last entry
//   toward a leaf. Rejected requests and a remove that empties the queue
//   skip the sift. The result sits in an output register, so a new request
//   is taken while the previous result waits; if m_ready stays low the
//   block finishes the next request and holds until the register frees.
//   Reset (aresetn low, synchronous) empties the queue; heap memory is
//   not cleared, and no slot's data is used before an insert writes it.
module binary_min_heap_queue_top import bmhq_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    cmd_t  cmd;
    stat_t st;

    // Sequencer
    bmhq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_data.action),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Heap storage and compare logic
    bmhq_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .st      (st),
        .m_data  (m_data)
    );

`ifndef ASSERT_OFF
    // One request at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted a request while busy");

    // Reported count never exceeds capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.entry_count <= 11'(CAPACITY)))
        else $error("count above capacity");

    // Empty flag agrees with count, head zeroed when empty
    a_empty_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.is_empty == (m_data.entry_count == '0)) &&
                    (!m_data.is_empty || (m_data.head_priority == '0 &&
                                          m_data.head_payload == '0)))
        else $error("empty flag inconsistent");

    // A rejected insert reports a full heap
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_FULL) |->
            (m_data.entry_count == 11'(CAPACITY)))
        else $error("full status with non-full count");
`endif

endmodule

[tb/heap_result_checker.sv]
// Result checker for the binary min-heap queue: follows both channels,
// keeps its own heap to predict each result and compares them in order.
// Depends on bmhq_pkg.
module heap_result_checker import bmhq_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  in_t  s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  out_t m_data,
    output int   mismatch_count,
    output int   results_due
);

    // Shadow heap and its fill level
    entry_t heap_mem [CAPACITY];
    int     heap_fill;

    // Predicted results, oldest first
    out_t   head_reports_q [$];
    int     mism;

    // Apply one request to the shadow heap and return the result it yields
    function automatic out_t heap_apply(in_t req);
        out_t   r;
        entry_t carried;
        entry_t tmp;
        int     pos;
        int     up;
        int     lc;
        int     rc;
        int     best;
        logic   moving;
        r = '0;
        r.status = ST_OK;
        if (req.action == ACT_INSERT) begin
            if (heap_fill >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                carried.prio = req.priority_req;
                carried.load = req.payload;
                pos = heap_fill;
                heap_fill++;
                // strict less-than: equal priorities stay below the parent
                moving = 1'b1;
                while (moving && pos != 0) begin
                    up = (pos - 1) / 2;
                    if ($signed(carried.prio) < $signed(heap_mem[up].prio)) begin
                        heap_mem[pos] = heap_mem[up];
                        pos = up;
                    end else begin
                        moving = 1'b0;
                    end
                end
                heap_mem[pos] = carried;
            end
        end else begin
            if (heap_fill == 0) begin
                r.status = ST_EMPTY;
            end else begin
                heap_fill--;
                heap_mem[0] = heap_mem[heap_fill];
                // sift down; the left child wins a tie
                pos = 0;
                moving = 1'b1;
                while (moving) begin
                    best = pos;
                    lc = 2 * pos + 1;
                    rc = 2 * pos + 2;
                    if (lc < heap_fill &&
                        $signed(heap_mem[lc].prio) < $signed(heap_mem[best].prio))
                        best = lc;
                    if (rc < heap_fill &&
                        $signed(heap_mem[rc].prio) < $signed(heap_mem[best].prio))
                        best = rc;
                    if (best == pos) begin
                        moving = 1'b0;
                    end else begin
                        tmp = heap_mem[pos];
                        heap_mem[pos] = heap_mem[best];
                        heap_mem[best] = tmp;
                        pos = best;
                    end
                end
            end
        end
        if (heap_fill != 0) begin
            r.head_priority = heap_mem[0].prio;
            r.head_payload  = heap_mem[0].load;
            r.is_empty      = 1'b0;
        end else begin
            r.is_empty = 1'b1;
        end
        r.entry_count = 11'(heap_fill);
        return r;
    endfunction

    // Compare finished transactions first, then record newly accepted ones
    always @(posedge aclk) begin
        out_t want;
        logic bad;
        if (!aresetn) begin
            heap_fill = 0;
            head_reports_q.delete();
            mism = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (head_reports_q.size() == 0) begin
                    mism++;
                    if (mism <= 10)
                        $display("[%0t] result with nothing outstanding: prio %0d payload %h",
                                 $realtime, m_data.head_priority, m_data.head_payload);
                end else begin
                    want = head_reports_q.pop_front();
                    bad = (m_data.head_priority != want.head_priority) ||
                          (m_data.head_payload  != want.head_payload)  ||
                          (m_data.entry_count   != want.entry_count)   ||
                          (m_data.is_empty      != want.is_empty)      ||
                          (m_data.status        != want.status);
                    if (bad) begin
                        mism++;
                        if (mism <= 10) begin
                            $display("[%0t] result mismatch", $realtime);
                            $display("  expected: prio %0d payload %h count %0d empty %b st %0d",
                                     want.head_priority, want.head_payload,
                                     want.entry_count, want.is_empty, want.status);
                            $display("  actual:   prio %0d payload %h count %0d empty %b st %0d",
                                     m_data.head_priority, m_data.head_payload,
                                     m_data.entry_count, m_data.is_empty, m_data.status);
                        end
                    end
                end
            end
            if (s_valid && s_ready)
                head_reports_q.push_back(heap_apply(s_data));
        end
        mismatch_count <= mism;
        results_due    <= head_reports_q.size();
    end

endmodule

[tb/tb.sv]
// Testbench top for the binary min-heap queue: clock, reset, request
// stimulus, result back-pressure and the verdict.
// Depends on bmhq_pkg, binary_min_heap_queue_top and heap_result_checker.
module tb import bmhq_pkg::*; ();

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 64;
    localparam int MAX_GAP     = 40;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    int          mismatch_count;
    int          results_due;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          occupancy     = 0;
    int unsigned cycle_count   = 0;

    binary_min_heap_queue_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    heap_result_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    always #5 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL binary_min_heap_queue_top");
            $finish;
        end
    end

    // Result back-pressure
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic in_t mk_insert(logic [31:0] prio, logic [31:0] load);
        in_t r;
        r.action       = ACT_INSERT;
        r.priority_req = prio;
        r.payload      = load;
        return r;
    endfunction

    // Remove carries random junk in the ignored fields
    function automatic in_t mk_remove();
        in_t r;
        r.action       = ACT_REMOVE;
        r.priority_req = $urandom;
        r.payload      = $urandom;
        return r;
    endfunction

    // Mix of tight ranges (ties), extremes and full-range keys
    function automatic logic [31:0] pick_priority();
        logic [31:0] p;
        case ($urandom_range(3))
            0: p = $urandom_range(16) - 8;
            1: begin
                case ($urandom_range(3))
                    0: p = 32'h8000_0000;
                    1: p = 32'h7FFF_FFFF;
                    2: p = 32'h0000_0000;
                    default: p = 32'hFFFF_FFFF;
                endcase
            end
            default: p = $urandom;
        endcase
        return p;
    endfunction

    // Present one request, with an optional idle gap, and hold until taken
    task automatic send_req(input in_t req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < MAX_GAP) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            gap++;
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        if (req.action == ACT_INSERT) begin
            if (occupancy < CAPACITY) occupancy++;
        end else if (occupancy > 0) begin
            occupancy--;
        end
    endtask

    // Sender holds off until every outstanding transaction has returned
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
    endtask

    task automatic send_random(input int insert_pct);
        if ($urandom_range(99) < insert_pct)
            send_req(mk_insert(pick_priority(), $urandom));
        else
            send_req(mk_remove());
    endtask

    initial begin
        in_t directed_q [$];

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sender idles lightly, receiver stalls heavily
        send_idle_pct = 20;
        recv_idle_pct = 86;

        // Directed: empty remove, left-child tie on sift down, extremes,
        // equal-priority insert under its parent, drain and empty remove
        directed_q.push_back(mk_remove());
        directed_q.push_back(mk_insert(32'd1, 32'h0000_0011));
        directed_q.push_back(mk_insert(32'd3, 32'h0000_0033));
        directed_q.push_back(mk_insert(32'd3, 32'h0000_0034));
        directed_q.push_back(mk_insert(32'd9, 32'h0000_0099));
        directed_q.push_back(mk_remove());
        directed_q.push_back(mk_insert(32'h0000_0000, 32'h0000_0000));
        directed_q.push_back(mk_insert(32'h7FFF_FFFF, 32'hFFFF_FFFF));
        directed_q.push_back(mk_insert(32'h8000_0000, 32'hAAAA_AAAA));
        directed_q.push_back(mk_insert(32'h8000_0000, 32'h5555_5555));
        repeat (7) directed_q.push_back(mk_remove());
        directed_q.push_back(mk_remove());
        foreach (directed_q[i]) send_req(directed_q[i]);
        drain_results();

        // Phase 1: random traffic under the same idling
        repeat (250) send_random(60);
        drain_results();

        // Phase 2: the other way round
        send_idle_pct = 86;
        recv_idle_pct = 20;
        repeat (250) send_random(45);
        drain_results();

        // Phase 3: no idling; mixed traffic, then fall to empty
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (120) send_random(50);
        while (occupancy > 0) send_random(25);
        repeat (2) send_req(mk_remove());

        drain_results();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0 && results_due == 0)
            $display("PASS binary_min_heap_queue_top");
        else
            $display("FAIL binary_min_heap_queue_top");
        $finish;
    end

endmodule
